FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the core of the multiply/divide unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMDM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Assertion failed in the multiply/divide unit.");

// The consequent must hold in the cycle after the antecedent.
`define CMDM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Assertion failed in the multiply/divide unit.");

`endif

FILE: hw/rtl/cmdm_pkg.sv
// Package with the codes, types and helper functions of the multiply/divide unit.
package cmdm_pkg;

   // Operation codes carried by the mode field.
   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_MUL  = 2'd1;
   localparam logic [1:0] MODE_DIV  = 2'd2;
   localparam logic [1:0] MODE_REM  = 2'd3;

   // Operand width codes carried by the width_sel field.
   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_32 = 2'd2;
   localparam logic [1:0] WIDTH_64 = 2'd3;

   localparam int unsigned DATA_W = 64;
   localparam int unsigned CNT_W  = $clog2(DATA_W);

   // One input item as the core sees it.
   typedef struct packed {
      logic [1:0]               mode;
      logic [1:0]               width_sel;
      logic signed [DATA_W-1:0] operand;
   } cmdm_item_type;

   // One result item as the core hands it to the output stage.
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     div_zero;
   } cmdm_result_type;

   // Wrap a value to the selected width and sign-extend it back to 64 bits.
   function automatic logic [DATA_W-1:0] sext_width(input logic [DATA_W-1:0] x,
                                                    input logic [1:0]        sel);
      logic [DATA_W-1:0] r;
      begin
         unique case (sel)
            WIDTH_8:  r = {{(DATA_W-8){x[7]}}, x[7:0]};
            WIDTH_16: r = {{(DATA_W-16){x[15]}}, x[15:0]};
            WIDTH_32: r = {{(DATA_W-32){x[31]}}, x[31:0]};
            default:  r = x;
         endcase
         return r;
      end
   endfunction

endpackage

FILE: hw/rtl/cmdm_req_if.sv
// Interface of the input channel: handshake plus one operation item.
interface cmdm_req_if
   import cmdm_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [1:0]               mode;
   logic [1:0]               width_sel;
   logic signed [DATA_W-1:0] operand;

   modport source (output valid, output mode, output width_sel, output operand,
                   input ready);
   modport sink (input valid, input mode, input width_sel, input operand,
                 output ready);
endinterface

FILE: hw/rtl/cmdm_rsp_if.sv
// Interface of the result channel: handshake plus one result item.
interface cmdm_rsp_if
   import cmdm_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] value;
   logic                     div_zero;

   modport source (output valid, output value, output div_zero, input ready);
   modport sink (input valid, input value, input div_zero, output ready);
endinterface

FILE: hw/rtl/cmdm_addsub.sv
// Shared 64-bit adder/subtractor used by the negation, step and fix-up states of the sequencer.
module cmdm_addsub
   import cmdm_pkg::*;
(
   input  logic [DATA_W-1:0] x,
   input  logic [DATA_W-1:0] y,
   input  logic              sub,
   output logic [DATA_W-1:0] sum,
   output logic              carry
);

   // x + y, or x - y as x + ~y + 1; carry out set means no borrow.
   assign {carry, sum} = {1'b0, x} + {1'b0, y ^ {DATA_W{sub}}} + {{DATA_W{1'b0}}, sub};

endmodule

FILE: hw/rtl/cmdm_core.sv
// Sequencer and registers that run multiply, divide and remainder on the shared adder.
`include "assert_macros.svh"

module cmdm_core
   import cmdm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  cmdm_item_type   in_item,
   output logic            out_valid,
   input  logic            out_ready,
   output cmdm_result_type out_result
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_NEG_A = 3'd1;
   localparam logic [2:0] ST_NEG_B = 3'd2;
   localparam logic [2:0] ST_STEP  = 3'd3;
   localparam logic [2:0] ST_FIX   = 3'd4;
   localparam logic [2:0] ST_WRITE = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic              err_ff, err_in;
   logic [1:0]        mode_ff, mode_in;
   logic [1:0]        width_ff, width_in;
   logic [DATA_W-1:0] a_ff, a_in;
   logic [DATA_W-1:0] b_ff, b_in;
   logic [DATA_W-1:0] r_ff, r_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              neg_a_ff, neg_a_in;
   logic              neg_b_ff, neg_b_in;

   logic              accept;
   logic [DATA_W-1:0] opnd_ext;
   logic [DATA_W-1:0] acc_ext;
   logic [DATA_W-1:0] add_x;
   logic [DATA_W-1:0] add_y;
   logic              add_sub;
   logic [DATA_W-1:0] add_sum;
   logic              add_carry;
   logic [DATA_W-1:0] fix_src;
   logic              fix_neg;

   assign in_ready  = (state_ff == ST_IDLE);
   assign accept    = in_valid && in_ready;
   assign out_valid = (state_ff == ST_WRITE);
   assign out_result.value    = res_ff;
   assign out_result.div_zero = err_ff;

   // Operands of this item wrapped to its width.
   assign opnd_ext = sext_width(in_item.operand, in_item.width_sel);
   assign acc_ext  = sext_width(acc_ff, in_item.width_sel);

   // Final fix-up picks the quotient or remainder and its sign.
   assign fix_src = (mode_ff == MODE_REM) ? r_ff : a_ff;
   assign fix_neg = (mode_ff == MODE_REM) ? neg_a_ff : (neg_a_ff ^ neg_b_ff);

   // Operand selection for the shared adder in each state.
   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_sub = 1'b0;
      unique case (state_ff)
         ST_NEG_A: begin
            add_y   = a_ff;
            add_sub = 1'b1;
         end
         ST_NEG_B: begin
            add_y   = b_ff;
            add_sub = 1'b1;
         end
         ST_STEP: begin
            if (mode_ff == MODE_MUL) begin
               add_x = {r_ff[DATA_W-2:0], 1'b0};
               add_y = b_ff[DATA_W-1] ? a_ff : '0;
            end else begin
               add_x   = {r_ff[DATA_W-2:0], a_ff[DATA_W-1]};
               add_y   = b_ff;
               add_sub = 1'b1;
            end
         end
         ST_FIX: begin
            add_y   = fix_src;
            add_sub = 1'b1;
         end
         default: begin
         end
      endcase
   end

   cmdm_addsub u_addsub (
      .x     (add_x),
      .y     (add_y),
      .sub   (add_sub),
      .sum   (add_sum),
      .carry (add_carry)
   );

   // Sequencer: set-up, one bit per step, sign fix-up, hand-off.
   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      err_in   = err_ff;
      mode_in  = mode_ff;
      width_in = width_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      r_in     = r_ff;
      res_in   = res_ff;
      cnt_in   = cnt_ff;
      neg_a_in = neg_a_ff;
      neg_b_in = neg_b_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in  = in_item.mode;
               width_in = in_item.width_sel;
               a_in     = acc_ext;
               b_in     = opnd_ext;
               r_in     = '0;
               cnt_in   = '0;
               neg_a_in = acc_ext[DATA_W-1];
               neg_b_in = opnd_ext[DATA_W-1];
               unique case (in_item.mode)
                  MODE_LOAD: begin
                     res_in   = opnd_ext;
                     err_in   = 1'b0;
                     state_in = ST_WRITE;
                  end
                  MODE_MUL: begin
                     state_in = ST_STEP;
                  end
                  default: begin
                     if (opnd_ext == '0) begin
                        res_in   = acc_ext;
                        err_in   = 1'b1;
                        state_in = ST_WRITE;
                     end else begin
                        state_in = ST_NEG_A;
                     end
                  end
               endcase
            end
         end
         ST_NEG_A: begin
            if (neg_a_ff) begin
               a_in = add_sum;
            end
            state_in = ST_NEG_B;
         end
         ST_NEG_B: begin
            if (neg_b_ff) begin
               b_in = add_sum;
            end
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (mode_ff == MODE_MUL) begin
               r_in = add_sum;
               b_in = {b_ff[DATA_W-2:0], 1'b0};
            end else begin
               r_in = add_carry ? add_sum : add_x;
               a_in = {a_ff[DATA_W-2:0], add_carry};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == {CNT_W{1'b1}}) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            if (mode_ff == MODE_MUL) begin
               res_in = sext_width(r_ff, width_ff);
            end else begin
               res_in = sext_width(fix_neg ? add_sum : fix_src, width_ff);
            end
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_ready) begin
               acc_in   = res_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and the architectural accumulator and flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         acc_ff   <= '0;
         err_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
         err_ff   <= err_in;
      end
   end

   // Working registers of the current item.
   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      width_ff <= width_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      r_ff     <= r_in;
      res_ff   <= res_in;
      cnt_ff   <= cnt_in;
      neg_a_ff <= neg_a_in;
      neg_b_ff <= neg_b_in;
   end

   `CMDM_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, accept, state_ff != ST_IDLE)
   `CMDM_ASSERT_NEXT(a_last_step_fixes, clock, reset,
                     (state_ff == ST_STEP) && (cnt_ff == {CNT_W{1'b1}}), state_ff == ST_FIX)
   `CMDM_ASSERT_NEXT(a_handoff_commits, clock, reset, out_valid && out_ready,
                     (state_ff == ST_IDLE) && (acc_ff == $past(res_ff)))
   `CMDM_ASSERT_SAME(a_ready_only_idle, clock, reset, in_ready, !out_valid)

endmodule

FILE: hw/rtl/chained_signed_mul_div_mod.sv
// Top level of the chained signed multiply/divide/remainder unit.
//
// Items fold a running signed value at 8, 16, 32 or 64 bits: a load item sets
// it, multiply, divide and remainder items apply the operand to it, and every
// item returns the new value sign-extended to 64 bits with a sticky divide-by-
// zero flag that the next load clears. All arithmetic runs on one shared 64-bit
// adder under a small sequencer, one bit per cycle, so the block takes one item
// at a time. A load or a zero-divisor item goes straight to the output hand-off,
// a multiply runs set-up, 64 shift-add steps and a wrap, and a divide or remainder
// runs two operand negations, 64 restoring steps and a sign fix-up. The output
// register lets the next item be accepted while a result still waits to be taken.
module chained_signed_mul_div_mod
   import cmdm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   cmdm_req_if.sink   req_ch,
   cmdm_rsp_if.source rsp_ch
);

   cmdm_item_type   core_item;
   cmdm_result_type core_result;
   logic            core_out_valid;
   logic            core_out_ready;
   logic            rsp_valid_ff, rsp_valid_in;
   cmdm_result_type rsp_data_ff, rsp_data_in;

   assign core_item.mode      = req_ch.mode;
   assign core_item.width_sel = req_ch.width_sel;
   assign core_item.operand   = req_ch.operand;

   cmdm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .in_item    (core_item),
      .out_valid  (core_out_valid),
      .out_ready  (core_out_ready),
      .out_result (core_result)
   );

   // The output register takes a new item when empty or being drained.
   assign core_out_ready = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (core_out_valid && core_out_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_result;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.value    = rsp_data_ff.value;
   assign rsp_ch.div_zero = rsp_data_ff.div_zero;

endmodule
